/* rtl/lzwtc_pkg.sv */
// Shared types and constants of the LZW trie compressor.
// Used by lzwtc_ctrl, lzwtc_dpath and lzw_trie_compressor; depends on nothing.
`timescale 1ns / 1ps

package lzwtc_pkg;

  localparam int DICT_DEPTH      = 512;
  localparam int ROOT_COUNT      = 256;
  localparam int MAX_BLOCK_CODES = 64;

  localparam int SYM_W  = 8;
  localparam int IDX_W  = $clog2(DICT_DEPTH);
  localparam int USED_W = $clog2(DICT_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_BLOCK_CODES + 1);
  localparam int CPB_W  = 7;

  localparam int CPB_RESET = 64;

  // configuration register indexes
  localparam int REG_CODES_PER_BLOCK = 0;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch letter, read child link of the match node
    logic walk_first;  // start walk at first child
    logic walk_next;   // step to next sibling
    logic mark_last;   // remember current node as tail of the list
    logic hit;         // move match node to current node
    logic alloc;       // append new node (if room)
    logic link;        // hook new node into the list
    logic emit;        // load result word, advance block state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic child_zero;
    logic letter_eq;
    logic sib_zero;
    logic full;
    logic out_free;
  } sts_t;

endpackage

/* rtl/lzwtc_ctrl.sv */
// Controller state machine of the LZW trie compressor.
// Depends on lzwtc_pkg; drives lzwtc_dpath through lzwtc_pkg::cmd_t.
`timescale 1ns / 1ps

module lzwtc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lzwtc_pkg::sts_t    sts,
  output lzwtc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHILD = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHILD;
        end
      end
      S_CHILD: begin
        if (sts.child_zero) begin
          state_nxt = S_ALLOC;
        end else begin
          cmd.walk_first = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.letter_eq) begin
          cmd.hit   = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.sib_zero) begin
          cmd.mark_last = 1'b1;
          state_nxt     = S_ALLOC;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = sts.full ? S_EMIT : S_LINK;
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lzwtc_dpath.sv */
// Datapath of the LZW trie compressor: node memories, match state and result register.
// Depends on lzwtc_pkg; commanded by lzwtc_ctrl.
`timescale 1ns / 1ps

module lzwtc_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lzwtc_pkg::cmd_t                     cmd,
  output lzwtc_pkg::sts_t                     sts,
  input  logic [lzwtc_pkg::SYM_W-1:0]         in_sym,
  input  logic [lzwtc_pkg::CPB_W-1:0]         codes_per_block,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [lzwtc_pkg::IDX_W-1:0]         out_code,
  output logic                                out_end,
  output logic                                out_full
);

  localparam int IDX_W  = lzwtc_pkg::IDX_W;
  localparam int SYM_W  = lzwtc_pkg::SYM_W;
  localparam int USED_W = lzwtc_pkg::USED_W;
  localparam int CNT_W  = lzwtc_pkg::CNT_W;
  localparam int DEPTH  = lzwtc_pkg::DICT_DEPTH;
  localparam int ROOTS  = lzwtc_pkg::ROOT_COUNT;

  // node memories
  logic [SYM_W-1:0] letter_mem [DEPTH];
  logic [IDX_W-1:0] sib_mem    [DEPTH];
  logic [IDX_W-1:0] child_mem  [DEPTH];

  logic [SYM_W-1:0]  letter_q;
  logic [IDX_W-1:0]  sib_q;
  logic [IDX_W-1:0]  child_q;

  logic [ROOTS-1:0]  root_vld_r, root_vld_nxt;
  logic [IDX_W-1:0]  match_r, match_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SYM_W-1:0]  sym_r;
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  last_r;
  logic              have_last_r;
  logic              miss_full_r;
  logic [IDX_W-1:0]  code_r;
  logic              end_r;
  logic              full_r;

  logic              match_is_root;
  logic [IDX_W-1:0]  child_eff;
  logic [IDX_W-1:0]  node_addr;
  logic [IDX_W-1:0]  new_idx;
  logic [IDX_W-1:0]  sym_idx;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  limit;
  logic              blk_end;
  logic              full;

  logic              sib_we;
  logic [IDX_W-1:0]  sib_wa, sib_wd;
  logic              child_we;
  logic [IDX_W-1:0]  child_wa, child_wd;
  logic              letter_we;

  assign match_is_root = (match_r < IDX_W'(ROOTS));
  assign child_eff     = (match_is_root && !root_vld_r[match_r[SYM_W-1:0]]) ? '0 : child_q;
  assign node_addr     = cmd.walk_first ? child_eff : sib_q;
  assign new_idx       = used_r[IDX_W-1:0];
  assign sym_idx       = {{(IDX_W-SYM_W){1'b0}}, sym_r};
  assign full          = (used_r >= USED_W'(DEPTH));

  // a zero register acts as one, anything above the maximum as the maximum
  always_comb begin
    if (codes_per_block == '0) begin
      limit = CNT_W'(1);
    end else if (codes_per_block > lzwtc_pkg::CPB_W'(lzwtc_pkg::MAX_BLOCK_CODES)) begin
      limit = CNT_W'(lzwtc_pkg::MAX_BLOCK_CODES);
    end else begin
      limit = CNT_W'(codes_per_block);
    end
  end

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign blk_end = (cnt_inc >= limit);

  // memory write ports: new node in ALLOC, list hook in LINK
  assign letter_we = cmd.alloc && !full;
  assign sib_we    = (cmd.alloc && !full) || (cmd.link && have_last_r);
  assign sib_wa    = cmd.alloc ? new_idx : last_r;
  assign sib_wd    = cmd.alloc ? '0 : new_idx;
  assign child_we  = (cmd.alloc && !full) || (cmd.link && !have_last_r);
  assign child_wa  = cmd.alloc ? new_idx : match_r;
  assign child_wd  = cmd.alloc ? '0 : new_idx;

  always_ff @(posedge clk) begin
    if (letter_we) begin
      letter_mem[new_idx] <= sym_r;
    end
    if (sib_we) begin
      sib_mem[sib_wa] <= sib_wd;
    end
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (cmd.accept) begin
      child_q <= child_mem[match_r];
    end
    if (cmd.walk_first || cmd.walk_next) begin
      letter_q <= letter_mem[node_addr];
      sib_q    <= sib_mem[node_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_r       <= in_sym;
      have_last_r <= 1'b0;
    end
    if (cmd.walk_first || cmd.walk_next) begin
      cur_r <= node_addr;
    end
    if (cmd.walk_next || cmd.mark_last) begin
      last_r      <= cur_r;
      have_last_r <= 1'b1;
    end
    if (cmd.alloc) begin
      miss_full_r <= full;
    end
    if (cmd.emit) begin
      code_r <= match_r;
      end_r  <= blk_end;
      full_r <= miss_full_r;
    end
  end

  always_comb begin
    root_vld_nxt  = root_vld_r;
    match_nxt     = match_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.hit) begin
      match_nxt = cur_r;
    end
    if (cmd.link) begin
      used_nxt = used_r + USED_W'(1);
      if (!have_last_r && match_is_root) begin
        root_vld_nxt[match_r[SYM_W-1:0]] = 1'b1;
      end
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (blk_end) begin
        cnt_nxt      = '0;
        match_nxt    = '0;
        used_nxt     = USED_W'(ROOTS);
        root_vld_nxt = '0;
      end else begin
        cnt_nxt   = cnt_inc;
        match_nxt = sym_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_vld_r  <= '0;
      match_r     <= '0;
      used_r      <= USED_W'(ROOTS);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      root_vld_r  <= root_vld_nxt;
      match_r     <= match_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.child_zero = (child_eff == '0);
  assign sts.letter_eq  = (letter_q == sym_r);
  assign sts.sib_zero   = (sib_q == '0);
  assign sts.full       = full;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_code   = code_r;
  assign out_end    = end_r;
  assign out_full   = full_r;

endmodule

/* rtl/lzw_trie_compressor.sv */
// Top level of the LZW trie compressor: stream ports, configuration port, assertions.
// Depends on lzwtc_pkg, lzwtc_ctrl and lzwtc_dpath.
`timescale 1ns / 1ps

// LZW compressor over 8-bit letters, dictionary held as a child/sibling trie.
// Input stream: one letter per word on in_tdata. Output stream: one code word
// per dictionary miss; a letter that extends the current match gives no word.
// out_tdata carries the 9-bit code, out_tuser flags block end and a refused
// insertion (dictionary full).
// Steps: a letter is taken in IDLE, its child link is read in CHILD and WALK
// inspects the child-list nodes; a hit returns to IDLE, a miss goes on through
// ALLOC, LINK (skipped with a full dictionary) and EMIT, where the code is
// loaded into the output register. The walk reads one node per cycle.
// Only one letter is in flight; in_tready is high while the controller idles.
// A finished code waits in the output register; the next letter is taken
// meanwhile, and the block stalls only when a second code needs that register
// before the receiver has taken the first.
// Reset (rst_n low at a clock edge) empties the dictionary to its 256 roots,
// sets the match to node 0, clears the code count and loads codes_per_block
// with 64. Block end clears the dictionary through per-root valid bits;
// no clearing pass is needed.
// Configuration: register codes_per_block at byte address 0; the user must write
// it only while the block is idle, the block itself does not enforce this.
module lzw_trie_compressor (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol_in
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [8:0] code_out, [15:9] zero
  output logic [1:0]  out_tuser,  // [0] block_end, [1] dict_full
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lzwtc_pkg::cmd_t cmd;
  lzwtc_pkg::sts_t sts;

  logic [lzwtc_pkg::CPB_W-1:0] cpb_r;
  logic [lzwtc_pkg::IDX_W-1:0] code;
  logic                        blk_end;
  logic                        dict_full;
  logic                        reg_sel;
  logic                        cfg_wr;

  // Register decode: paddr[2] selects codes_per_block at word address 0; the other word reads zero.
  assign reg_sel    = (cfg_paddr[2] == 1'(lzwtc_pkg::REG_CODES_PER_BLOCK));
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? 32'(cpb_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r <= lzwtc_pkg::CPB_W'(lzwtc_pkg::CPB_RESET);
    end else if (cfg_wr && reg_sel) begin
      cpb_r <= cfg_pwdata[lzwtc_pkg::CPB_W-1:0];
    end
  end

  lzwtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzwtc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sym          (in_tdata),
    .codes_per_block (cpb_r),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_code        (code),
    .out_end         (blk_end),
    .out_full        (dict_full)
  );

  // Pack the result word.
  assign out_tdata = {{(16 - lzwtc_pkg::IDX_W){1'b0}}, code};
  assign out_tuser = {dict_full, blk_end};

  // Hooking a node into a list only follows an insertion that found room.
  a_link_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link |-> !sts.full)
    else $error("list link issued with a full dictionary");

  // A new code never overwrites one the receiver has not taken.
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while stalled");

  // One letter in flight: an accepted word closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second letter accepted while one is in flight");

  // A walk step and an insertion are never commanded together.
  a_walk_vs_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_first || cmd.walk_next) |-> !(cmd.alloc || cmd.link || cmd.emit))
    else $error("walk overlaps insertion");

endmodule

/* test/tb_lzw_trie_compressor.sv */
// Self-checking testbench of lzw_trie_compressor: random-gap stream driver, monitor
// with its own trie predictor, APB register writes and read-backs between phases.
// Depends on lzwtc_pkg and the lzw_trie_compressor RTL.
`timescale 1ns / 1ps

module tb_lzw_trie_compressor;

  localparam int SYM_W               = lzwtc_pkg::SYM_W;
  localparam int IDX_W               = lzwtc_pkg::IDX_W;
  localparam int USED_W              = lzwtc_pkg::USED_W;
  localparam int CNT_W               = lzwtc_pkg::CNT_W;
  localparam int CPB_W               = lzwtc_pkg::CPB_W;
  localparam int DICT_DEPTH          = lzwtc_pkg::DICT_DEPTH;
  localparam int ROOT_COUNT          = lzwtc_pkg::ROOT_COUNT;
  localparam int MAX_BLOCK_CODES     = lzwtc_pkg::MAX_BLOCK_CODES;
  localparam int CPB_RESET           = lzwtc_pkg::CPB_RESET;
  localparam int REG_CODES_PER_BLOCK = lzwtc_pkg::REG_CODES_PER_BLOCK;

  // Silence after the last expected code: a letter that extends the match
  // gives no word but may still be walking a child list.
  localparam int SETTLE_CYCLES = 150;
  // Slowest correct progress: the longest send gap, a walk of at most 64 nodes
  // (one block appends no more), the longest receive stall, plus the settle pause.
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [SYM_W-1:0] OPENING [24] = '{
    8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
    8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42,
    8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43
  };

  typedef struct packed {
    logic [IDX_W-1:0] code;
    logic             block_end;
    logic             dict_full;
  } code_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] symbol_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [8:0] code_out, [15:9] zero
  logic [1:0]  out_tuser;        // [0] block_end, [1] dict_full
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lzw_trie_compressor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Trie predictor: own copy of the dictionary, match node and block state.
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0]  trie_letter  [DICT_DEPTH];
  logic [IDX_W-1:0]  trie_sibling [DICT_DEPTH];
  logic [IDX_W-1:0]  trie_child   [DICT_DEPTH];
  logic [IDX_W-1:0]  cur_match;
  logic [USED_W-1:0] nodes_used;
  logic [CNT_W-1:0]  block_count;
  logic [CPB_W-1:0]  block_len;

  // Drop every appended node; roots keep their own letter and lose all links.
  function automatic void clear_trie();
    for (int i = 0; i < DICT_DEPTH; i++) begin
      trie_letter[i]  = (i < ROOT_COUNT) ? SYM_W'(i) : '0;
      trie_sibling[i] = '0;
      trie_child[i]   = '0;
    end
    nodes_used = USED_W'(ROOT_COUNT);
    cur_match  = '0;
  endfunction

  // Advance the trie by one letter; return 1 and the code word on a miss.
  function automatic bit predict_code(input logic [SYM_W-1:0] sym,
                                      output code_word_t word);
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] tail;
    bit               have_tail;
    int               steps;
    int               limit;
    int               fresh;
    node      = trie_child[cur_match];
    tail      = '0;
    have_tail = 1'b0;
    steps     = 0;
    word      = '0;
    // Walk the child list; a zero link ends it.
    while (node != '0 && steps < DICT_DEPTH) begin
      if (trie_letter[node] == sym) begin
        cur_match = node;
        return 1'b0;
      end
      tail      = node;
      have_tail = 1'b1;
      node      = trie_sibling[node];
      steps++;
    end
    // Miss: append at the tail of the list unless every entry is taken.
    if (nodes_used >= USED_W'(DICT_DEPTH)) begin
      word.dict_full = 1'b1;
    end else begin
      fresh = int'(nodes_used);
      trie_letter[fresh]  = sym;
      trie_sibling[fresh] = '0;
      trie_child[fresh]   = '0;
      if (have_tail) begin
        trie_sibling[tail] = IDX_W'(fresh);
      end else begin
        trie_child[cur_match] = IDX_W'(fresh);
      end
      nodes_used = nodes_used + 1'b1;
    end
    word.code = cur_match;
    cur_match = IDX_W'(sym);
    // A length of 0 acts as 1, anything above the maximum as the maximum.
    limit = (block_len == '0) ? 1 : int'(block_len);
    if (limit > MAX_BLOCK_CODES) limit = MAX_BLOCK_CODES;
    block_count = block_count + 1'b1;
    if (int'(block_count) >= limit) begin
      word.block_end = 1'b1;
      block_count    = '0;
      clear_trie();
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and counters shared by the sequencer, driver and monitor.
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0] letter_q [$];
  code_word_t       code_q [$];
  int               letters_queued = 0;
  int               letters_taken = 0;
  int               mismatch_count = 0;
  int               in_gap = 0;
  int               in_gap_max = 13;
  int               out_stall = 0;
  int               out_stall_max = 13;
  int               idle_cycles = 0;

  // Driver: hold a word until it is taken, then idle for its drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (letter_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= letter_q.pop_front();
        in_gap    <= $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: after each taken word, stall for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_tvalid && out_tready) begin
      out_stall  <= $urandom_range(0, out_stall_max);
      out_tready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: check the code word first, then predict from the taken letter,
  // so a word can never be matched against an expectation of the same edge.
  code_word_t want;
  code_word_t seen;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = '{code: out_tdata[IDX_W-1:0], block_end: out_tuser[0],
                 dict_full: out_tuser[1]};
        if (code_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected code word: expected none, actual tdata=%h tuser=%b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = code_q.pop_front();
          if (out_tdata != 16'(want.code)) begin
            mismatch_count++;
            $display("%0t: code_out: expected %0d, actual tdata=%h",
                     $time, want.code, out_tdata);
          end
          if (seen.block_end != want.block_end) begin
            mismatch_count++;
            $display("%0t: block_end: expected %b, actual %b",
                     $time, want.block_end, seen.block_end);
          end
          if (seen.dict_full != want.dict_full) begin
            mismatch_count++;
            $display("%0t: dict_full: expected %b, actual %b",
                     $time, want.dict_full, seen.dict_full);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        letters_taken++;
        if (predict_code(in_tdata, want)) code_q.push_back(want);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("lzw_trie_compressor: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_letter(input logic [SYM_W-1:0] sym);
    letter_q.push_back(sym);
    letters_queued++;
  endtask

  // Mostly repeated phrases over a narrow alphabet, so matches run deep;
  // the rest is narrow-alphabet chatter and full-range noise.
  task automatic queue_letters(input int count);
    logic [SYM_W-1:0] phrase [8];
    logic [SYM_W-1:0] base;
    int               left;
    int               mode;
    int               span;
    int               plen;
    int               reps;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(0, 9);
      base = SYM_W'($urandom);
      span = $urandom_range(2, 4);
      if (mode < 6) begin
        plen = $urandom_range(1, 8);
        for (int i = 0; i < plen; i++) phrase[i] = base + SYM_W'($urandom_range(0, span - 1));
        reps = $urandom_range(2, 6);
        for (int r = 0; r < reps; r++) begin
          for (int i = 0; i < plen && left > 0; i++) begin
            queue_letter(phrase[i]);
            left--;
          end
        end
      end else if (mode < 9) begin
        for (int i = 0; i < 10 && left > 0; i++) begin
          queue_letter(base + SYM_W'($urandom_range(0, span - 1)));
          left--;
        end
      end else begin
        for (int i = 0; i < 8 && left > 0; i++) begin
          queue_letter(SYM_W'($urandom));
          left--;
        end
      end
    end
  endtask

  // Wait until every queued letter is taken and every expected word has come.
  task automatic wait_drained();
    while (letters_taken != letters_queued || code_q.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= 3'(idx * 4);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_block_len();
    logic [31:0] rdata;
    cfg_access(1'b0, REG_CODES_PER_BLOCK, '0, rdata);
    if (rdata != 32'(block_len)) begin
      mismatch_count++;
      $display("%0t: codes_per_block read: expected %0d, actual %0d",
               $time, block_len, rdata);
    end
  endtask

  // Write the block length while idle, read it back, set idling, queue letters, drain, settle.
  task automatic run_phase(input logic [31:0] len_value, input int count,
                           input int gap_in, input int gap_out);
    logic [31:0] unused;
    cfg_access(1'b1, REG_CODES_PER_BLOCK, len_value, unused);
    block_len = len_value[CPB_W-1:0];
    check_block_len();
    in_gap_max    = gap_in;
    out_stall_max = gap_out;
    queue_letters(count);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clear_trie();
    block_count = '0;
    block_len   = CPB_W'(CPB_RESET);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset length of 64: start-of-block lookups under root 0, extreme
    // letters, repeated pairs and triples that grow chains, then random text.
    check_block_len();
    foreach (OPENING[i]) queue_letter(OPENING[i]);
    queue_letters(240);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Lower the length to 3, possibly below the codes already counted: then the next code ends the block.
    run_phase(32'd3, 120, 0, 0);
    // One code per block.
    run_phase(32'd1, 40, 13, 0);
    // Upper bits are dropped; a length of 0 acts as 1.
    run_phase(32'h0000_0180, 40, 0, 13);

    // Largest register value acts as the maximum; pause the sender midway
    // until every expected word has come.
    run_phase(32'd127, 0, 13, 13);
    queue_letters(125);
    wait_drained();
    queue_letters(125);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    run_phase(32'd65, 150, 13, 0);
    run_phase(32'd64, 120, 0, 13);
    for (int p = 0; p < 3; p++) begin
      run_phase(32'($urandom_range(2, 63)), 80, $urandom_range(0, 1) * 13,
                $urandom_range(0, 1) * 13);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (code_q.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d code words never arrived", $time, code_q.size());
    end
    if (mismatch_count == 0) begin
      $display("lzw_trie_compressor: match");
    end else begin
      $display("lzw_trie_compressor: mismatch");
    end
    $finish;
  end

endmodule
